>>> hw/rtl/oahs_pkg.sv
// oahs_pkg: shared types and constants of the open-address hash insert/search unit
// holds the payload structs, status codes and register indexes
// no dependencies
package oahs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS    = 16;
    localparam int ADDR_BITS   = 10;
    localparam int SIZE_BITS   = 11;
    localparam int PROBE_BITS  = 11;
    localparam int CFG_BITS    = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int CNT_BITS    = $clog2(KEY_BITS);

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ABSENT   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_MODE = 1'd1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic MODE_QUAD   = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [KEY_BITS-1:0] key;
    } in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [ADDR_BITS-1:0]  slot;
        logic [PROBE_BITS-1:0] probes_examined;
    } out_t;

endpackage

>>> hw/rtl/open_address_hash_insert_search_unit.sv
// open_address_hash_insert_search_unit: open-addressing hash table, insert or search per transfer
// one shared bit-serial remainder unit, probe sequencer and a slot memory with one write and one read port
// depends on oahs_pkg
//
//   channel  | signals                      | moves
//   ---------+------------------------------+-------------------------------
//   in       | in_valid, in_stall, in_item  | kind and key, one per operation
//   out      | out_valid, out_stall, out_item | status, slot, probes_examined
//   cfg      | cfg_we, cfg_index, cfg_data  | table_size, probe_mode writes
//
// an operation reduces the key mod n in the shared remainder unit, one key bit per cycle,
// once for the home slot (quadratic) or twice, home slot and step (double hashing), then
// reads and checks each slot examined (registered memory read, then compare), then
// loads the output register; a zero key skips the remainders and probes. after reset a
// clearing pass writes zero to all 1024 slots, during which in_stall is high. out_stall only
// holds the unit in its finish state when the previous result has not yet been taken
module open_address_hash_insert_search_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  oahs_pkg::in_t                        in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output oahs_pkg::out_t                       out_item,
    input  logic                                 cfg_we,
    input  logic [oahs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [oahs_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int AB = oahs_pkg::ADDR_BITS;
    localparam int SB = oahs_pkg::SIZE_BITS;
    localparam int KB = oahs_pkg::KEY_BITS;
    localparam int CB = oahs_pkg::CNT_BITS;
    localparam int PB = oahs_pkg::PROBE_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_MOD_HOME,
        S_MOD_STEP,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [SB-1:0] table_size_reg, table_size_next;
    logic          probe_mode_reg, probe_mode_next;

    logic [AB-1:0] clr_cnt_reg, clr_cnt_next;
    logic          kind_reg, kind_next;
    logic [KB-1:0] key_reg, key_next;
    logic          mode_reg, mode_next;
    logic [SB-1:0] n_reg, n_next;
    logic [KB-1:0] key_sh_reg, key_sh_next;
    logic [SB-1:0] rem_reg, rem_next;
    logic [CB-1:0] bit_cnt_reg, bit_cnt_next;
    logic [AB-1:0] addr_reg, addr_next;
    logic [SB-1:0] step_reg, step_next;
    logic [SB-1:0] sq_reg, sq_next;
    logic [SB-1:0] incr_reg, incr_next;
    logic [PB-1:0] exam_reg, exam_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [AB-1:0] res_slot_reg, res_slot_next;
    logic [PB-1:0] res_probes_reg, res_probes_next;
    logic          out_valid_reg, out_valid_next;
    oahs_pkg::out_t out_item_reg, out_item_next;

    // slot store
    logic [KB-1:0] mem [oahs_pkg::TABLE_DEPTH];
    logic [KB-1:0] rd_data_reg;
    logic          mem_we;
    logic [AB-1:0] mem_waddr;
    logic [KB-1:0] mem_wdata;

    // datapath
    logic [SB-1:0] size_in_use;
    logic [SB-1:0] mod_div;
    logic [SB:0]   mod_trial;
    logic [SB:0]   mod_diff;
    logic [SB-1:0] mod_rem;
    logic [SB:0]   addr_sum;
    logic [SB:0]   addr_red;
    logic [SB:0]   sq_sum;
    logic [SB:0]   sq_red;
    logic [SB:0]   incr_sum;
    logic [SB:0]   incr_red;
    logic [SB:0]   incr_init;
    logic [PB-1:0] exam_inc;
    logic          slot_empty;
    logic          slot_match;

    assign size_in_use = (table_size_reg < SB'(3)) ? SB'(3) :
                         (table_size_reg > SB'(oahs_pkg::TABLE_DEPTH)) ?
                         SB'(oahs_pkg::TABLE_DEPTH) : table_size_reg;

    // restoring remainder, one key bit per cycle, msb first
    assign mod_div   = (state_reg == S_MOD_STEP) ? (n_reg - SB'(2)) : n_reg;
    assign mod_trial = {rem_reg, key_sh_reg[KB-1]};
    assign mod_diff  = mod_trial - {1'b0, mod_div};
    assign mod_rem   = (mod_trial >= {1'b0, mod_div}) ? mod_diff[SB-1:0] : mod_trial[SB-1:0];

    // next probe address, both operands below n so one subtract reduces it
    assign addr_sum = {{(SB+1-AB){1'b0}}, addr_reg} +
                      {1'b0, (mode_reg == oahs_pkg::MODE_QUAD) ? sq_reg : step_reg};
    assign addr_red = (addr_sum >= {1'b0, n_reg}) ? (addr_sum - {1'b0, n_reg}) : addr_sum;

    // p squared kept mod n: (p+1)^2 = p^2 + (2p+1), and 2p+1 grows by two
    assign sq_sum    = {1'b0, sq_reg} + {1'b0, incr_reg};
    assign sq_red    = (sq_sum >= {1'b0, n_reg}) ? (sq_sum - {1'b0, n_reg}) : sq_sum;
    assign incr_sum  = {1'b0, incr_reg} + (SB+1)'(2);
    assign incr_red  = (incr_sum >= {1'b0, n_reg}) ? (incr_sum - {1'b0, n_reg}) : incr_sum;
    assign incr_init = ((SB+1)'(3) >= {1'b0, n_reg}) ? ((SB+1)'(3) - {1'b0, n_reg}) :
                       (SB+1)'(3);

    assign exam_inc   = exam_reg + PB'(1);
    assign slot_empty = (rd_data_reg == '0);
    assign slot_match = (rd_data_reg == key_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = key_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_CHECK && kind_reg == oahs_pkg::KIND_INSERT && slot_empty)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        table_size_next = table_size_reg;
        probe_mode_next = probe_mode_reg;
        clr_cnt_next    = clr_cnt_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        mode_next       = mode_reg;
        n_next          = n_reg;
        key_sh_next     = key_sh_reg;
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        addr_next       = addr_reg;
        step_next       = step_reg;
        sq_next         = sq_reg;
        incr_next       = incr_reg;
        exam_next       = exam_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_probes_next = res_probes_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                oahs_pkg::REG_TABLE_SIZE: table_size_next = cfg_data[SB-1:0];
                oahs_pkg::REG_PROBE_MODE: probe_mode_next = cfg_data[0];
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AB'(1);
                if (clr_cnt_reg == AB'(oahs_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_item.kind;
                    key_next   = in_item.key;
                    mode_next  = probe_mode_reg;
                    n_next     = size_in_use;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                key_sh_next  = key_reg;
                rem_next     = '0;
                bit_cnt_next = '0;
                sq_next      = SB'(1);
                incr_next    = incr_init[SB-1:0];
                exam_next    = '0;
                if (key_reg == '0)
                begin
                    res_status_next = (kind_reg == oahs_pkg::KIND_SEARCH) ?
                                      oahs_pkg::ST_ABSENT : oahs_pkg::ST_FULL;
                    res_slot_next   = '0;
                    res_probes_next = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_MOD_HOME;
                end
            end
            S_MOD_HOME, S_MOD_STEP:
            begin
                key_sh_next  = {key_sh_reg[KB-2:0], 1'b0};
                rem_next     = mod_rem;
                bit_cnt_next = bit_cnt_reg + CB'(1);
                if (bit_cnt_reg == CB'(KB - 1))
                begin
                    if (state_reg == S_MOD_HOME)
                    begin
                        addr_next = mod_rem[AB-1:0];
                        if (mode_reg == oahs_pkg::MODE_DOUBLE)
                        begin
                            key_sh_next  = key_reg;
                            rem_next     = '0;
                            bit_cnt_next = '0;
                            state_next   = S_MOD_STEP;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        step_next  = mod_rem + SB'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                exam_next = exam_inc;
                if (kind_reg == oahs_pkg::KIND_INSERT && slot_empty)
                begin
                    res_status_next = oahs_pkg::ST_INSERTED;
                    res_slot_next   = addr_reg;
                    res_probes_next = exam_inc;
                    state_next      = S_FINISH;
                end
                else if (kind_reg == oahs_pkg::KIND_SEARCH && slot_match)
                begin
                    res_status_next = oahs_pkg::ST_FOUND;
                    res_slot_next   = addr_reg;
                    res_probes_next = exam_inc;
                    state_next      = S_FINISH;
                end
                else if (kind_reg == oahs_pkg::KIND_SEARCH && slot_empty)
                begin
                    res_status_next = oahs_pkg::ST_ABSENT;
                    res_slot_next   = '0;
                    res_probes_next = exam_inc;
                    state_next      = S_FINISH;
                end
                else if (exam_inc == n_reg)
                begin
                    // whole probe budget spent
                    res_status_next = (kind_reg == oahs_pkg::KIND_SEARCH) ?
                                      oahs_pkg::ST_ABSENT : oahs_pkg::ST_FULL;
                    res_slot_next   = '0;
                    res_probes_next = exam_inc;
                    state_next      = S_FINISH;
                end
                else
                begin
                    addr_next = addr_red[AB-1:0];
                    sq_next   = sq_red[SB-1:0];
                    incr_next = incr_red[SB-1:0];
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.status          = res_status_reg;
                    out_item_next.slot            = res_slot_reg;
                    out_item_next.probes_examined = res_probes_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            table_size_reg <= SB'(1024);
            probe_mode_reg <= oahs_pkg::MODE_QUAD;
            clr_cnt_reg    <= '0;
            kind_reg       <= 1'b0;
            key_reg        <= '0;
            mode_reg       <= 1'b0;
            n_reg          <= SB'(3);
            key_sh_reg     <= '0;
            rem_reg        <= '0;
            bit_cnt_reg    <= '0;
            addr_reg       <= '0;
            step_reg       <= '0;
            sq_reg         <= '0;
            incr_reg       <= '0;
            exam_reg       <= '0;
            res_status_reg <= '0;
            res_slot_reg   <= '0;
            res_probes_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            probe_mode_reg <= probe_mode_next;
            clr_cnt_reg    <= clr_cnt_next;
            kind_reg       <= kind_next;
            key_reg        <= key_next;
            mode_reg       <= mode_next;
            n_reg          <= n_next;
            key_sh_reg     <= key_sh_next;
            rem_reg        <= rem_next;
            bit_cnt_reg    <= bit_cnt_next;
            addr_reg       <= addr_next;
            step_reg       <= step_next;
            sq_reg         <= sq_next;
            incr_reg       <= incr_next;
            exam_reg       <= exam_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_probes_reg <= res_probes_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> hw/rtl/oahs_checker.sv
// oahs_checker: port-level assertions for the open-address hash insert/search unit
// bound to the top level below; depends on oahs_pkg
module oahs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input oahs_pkg::out_t out_item
);

    // an accepted transfer keeps the unit busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after a transfer");

    // a result is presented as the unit goes back to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while the unit is still busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");

    // failures report slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status == oahs_pkg::ST_FULL ||
                       out_item.status == oahs_pkg::ST_ABSENT)) |-> (out_item.slot == '0))
        else $error("failure with nonzero slot");

    // a hit examined at least one slot, never more than the store holds
    a_hit_probes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status == oahs_pkg::ST_INSERTED ||
                       out_item.status == oahs_pkg::ST_FOUND)) |->
        (out_item.probes_examined != '0 &&
         out_item.probes_examined <= oahs_pkg::PROBE_BITS'(oahs_pkg::TABLE_DEPTH)))
        else $error("hit with bad probe count");

endmodule

bind open_address_hash_insert_search_unit oahs_checker u_oahs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
